// ----- rtl/cbq_pkg.sv -----
// cbq_pkg: types and constants shared by the circular byte queue and its checker
// no dependencies

package cbq_pkg;

   localparam int IDX_W  = 10;
   localparam int SIZE_W = 11;
   localparam int LEN_W  = 10;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_NO_DATA = 2'd2,
      ST_BAD_LEN = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [7:0]        data_byte;
      logic [LEN_W-1:0]  run_length;
      logic              first_of_run;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  seg0_offset;
      logic [LEN_W-1:0]  seg0_length;
      logic [LEN_W-1:0]  seg1_length;
      logic [IDX_W-1:0]  fill_count;
      logic [IDX_W-1:0]  free_room;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

endpackage

// ----- rtl/circular_byte_queue.sv -----
// circular_byte_queue: byte ring buffer with head/tail indices, one slot kept empty
// depends on cbq_pkg
//
// One command is taken per clock whenever busy is low (busy is high during
// reset and in the cycle after it). Each command gives exactly one response,
// strobed by rsp_valid from the result register that follows the input
// register; the response cannot be held off. The path holds one input register
// and one result register around the index compare/advance logic, with the byte
// store written in the same cycle as the result register. The ring uses size_ff
// slots, clamped to 2..min(DEPTH,1024); writing csr_wdata sets the size and
// clears both indices and any open write run. The byte store needs no clearing pass.

module circular_byte_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  cbq_pkg::req_type                       req_item,
   output logic                                   rsp_valid,
   output cbq_pkg::rsp_type                       rsp_item,
   input  logic                                   csr_we,
   input  logic [cbq_pkg::SIZE_W-1:0]             csr_wdata
);
   import cbq_pkg::*;

   localparam int MAX_SIZE = (DEPTH < 1024) ? DEPTH : 1024;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                 busy_ff;
   logic                 vld_ff;
   req_type              req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [SIZE_W-1:0]    size_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [LEN_W-1:0]     run_left_ff, run_left_in;
   logic [7:0]           store_mem [DEPTH];
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   logic [SIZE_W-1:0]    cnt, room, len, to_end;
   logic [SIZE_W-1:0]    t_inc, t_adv, h_adv;
   logic [SIZE_W-1:0]    cnt_post, room_post;

   function automatic logic [SIZE_W-1:0] held(input logic [IDX_W-1:0] h,
                                               input logic [IDX_W-1:0] t,
                                               input logic [SIZE_W-1:0] s);
      if (t >= h) begin
         return {1'b0, t} - {1'b0, h};
      end
      return s - {1'b0, h} + {1'b0, t};
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      if (v < SIZE_W'(2)) begin
         return SIZE_W'(2);
      end
      if (v > SIZE_W'(MAX_SIZE)) begin
         return SIZE_W'(MAX_SIZE);
      end
      return v;
   endfunction

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign wr_addr   = AW'(tail_ff);

   always_comb begin
      cnt    = held(head_ff, tail_ff, size_ff);
      room   = size_ff - SIZE_W'(1) - cnt;
      len    = {1'b0, req_ff.run_length};
      to_end = size_ff - {1'b0, head_ff};
      t_inc  = {1'b0, tail_ff} + SIZE_W'(1);
      if (t_inc == size_ff) begin
         t_inc = '0;
      end
      t_adv = {1'b0, tail_ff} + len;
      if (t_adv >= size_ff) begin
         t_adv = t_adv - size_ff;
      end
      h_adv = {1'b0, head_ff} + len;
      if (h_adv >= size_ff) begin
         h_adv = h_adv - size_ff;
      end

      head_in     = head_ff;
      tail_in     = tail_ff;
      run_left_in = run_left_ff;
      wr_en       = 1'b0;
      rsp_in      = '0;
      rsp_in.status = ST_OK;

      case (req_ff.cmd)
         CMD_WRITE: begin
            if (req_ff.first_of_run) begin
               run_left_in = '0;
               if (len == '0) begin
                  rsp_in.status = ST_BAD_LEN;
               end else if (len > room) begin
                  rsp_in.status = ST_NO_ROOM;
               end else begin
                  wr_en       = 1'b1;
                  run_left_in = req_ff.run_length - LEN_W'(1);
               end
            end else if (run_left_ff == '0) begin
               rsp_in.status = ST_BAD_LEN;
            end else if (room == '0) begin
               rsp_in.status = ST_NO_ROOM;
               run_left_in   = '0;
            end else begin
               wr_en       = 1'b1;
               run_left_in = run_left_ff - LEN_W'(1);
            end
            if (wr_en) begin
               tail_in = t_inc[IDX_W-1:0];
            end
         end
         CMD_READ: begin
            if (len == '0) begin
               rsp_in.status = ST_BAD_LEN;
            end else if (len > cnt) begin
               rsp_in.status = ST_NO_DATA;
            end else begin
               rsp_in.seg0_offset = head_ff;
               if (len <= to_end) begin
                  rsp_in.seg0_length = req_ff.run_length;
               end else begin
                  rsp_in.seg0_length = to_end[LEN_W-1:0];
                  rsp_in.seg1_length = LEN_W'(len - to_end);
               end
               head_in = h_adv[IDX_W-1:0];
            end
         end
         CMD_RESERVE: begin
            if (len == '0) begin
               rsp_in.status = ST_BAD_LEN;
            end else if (len > room) begin
               rsp_in.status = ST_NO_ROOM;
            end else begin
               tail_in = t_adv[IDX_W-1:0];
            end
         end
         default: begin
            head_in     = '0;
            tail_in     = '0;
            run_left_in = '0;
         end
      endcase

      cnt_post          = held(head_in, tail_in, size_ff);
      room_post         = size_ff - SIZE_W'(1) - cnt_post;
      rsp_in.fill_count = cnt_post[IDX_W-1:0];
      rsp_in.free_room  = room_post[IDX_W-1:0];
      rsp_in.is_empty   = (head_in == tail_in);
      rsp_in.is_full    = (room_post == '0);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_item;
      end
   end

   // ring state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= clamp_size(SIZE_W'(1024));
         head_ff      <= '0;
         tail_ff      <= '0;
         run_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff;
         if (csr_we) begin
            size_ff     <= clamp_size(csr_wdata);
            head_ff     <= '0;
            tail_ff     <= '0;
            run_left_ff <= '0;
         end else if (vld_ff) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            run_left_ff <= run_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // byte store
   always_ff @(posedge clock) begin
      if (vld_ff && wr_en && !csr_we) begin
         store_mem[wr_addr] <= req_ff.data_byte;
      end
   end

endmodule

// ----- rtl/cbq_checker.sv -----
// cbq_checker: port-level assertions for circular_byte_queue, bound to circular_byte_queue
// depends on cbq_pkg and circular_byte_queue

module cbq_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       rsp_valid,
   input  cbq_pkg::rsp_type           rsp_item
);
   import cbq_pkg::*;

   // every command transfer is answered by rsp_valid
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("command transfer without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without command transfer");

   // empty and full flags agree with the counts
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.is_empty == (rsp_item.fill_count == '0)) &&
                     (rsp_item.is_full == (rsp_item.free_room == '0))))
      else $error("flags disagree with counts");

   // segment fields stay zero on any failed command
   a_seg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |->
         (rsp_item.seg0_offset == '0 && rsp_item.seg0_length == '0 &&
          rsp_item.seg1_length == '0))
      else $error("segment fields set on failed command");

endmodule

bind circular_byte_queue cbq_checker u_cbq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
